>>> rtl/ubx_pkg.sv
// ----------------------------------------------------------------------------
// ubx_pkg: shared types and constants of the raw-measurement frame parser
// Holds the sync bytes, frame geometry, the token passed from the byte
// classifier to the result assembler, and the queue depth default.
// ----------------------------------------------------------------------------
package ubx_pkg;

	// sync pair that opens every frame
	localparam logic [7:0] SYNC_FIRST  = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;

	// frame geometry in bytes
	localparam int BLOCK_BYTES  = 24;
	localparam int HEADER_BYTES = 8;

	// result word width: tow, week, num_sv, phase, range, doppler, four bytes
	localparam int OUT_W = 32 + 16 + 8 + 64 + 64 + 32 + 8 + 8 + 8 + 8;

	// token queue depth between classifier and assembler
	localparam int QUEUE_DEPTH = 4;

	// role of one payload byte
	typedef enum logic [3:0] {
		OP_TOW,
		OP_WEEK,
		OP_NSV,
		OP_HDR_END,
		OP_PHASE,
		OP_RANGE,
		OP_DOPPLER,
		OP_SMALL,
		OP_BLK_END
	} op_t;

	// one classified byte
	typedef struct packed {
		op_t        op;
		logic       last;
		logic [7:0] data;
	} tok_t;

	// result kinds on tuser
	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_RECORD = 1'b1;

endpackage

>>> rtl/ubx_front.sv
// ----------------------------------------------------------------------------
// ubx_front: byte classifier
// Walks the frame structure one byte per cycle while bytes are accepted, drops framing and skipped
// bytes, and tags each useful payload byte with its role for the assembler.
// ----------------------------------------------------------------------------
module ubx_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_valid,
	input  logic          byte_ready,
	input  logic [7:0]    byte_data,
	output logic          tok_valid,
	output ubx_pkg::tok_t tok
);
	import ubx_pkg::*;

	typedef enum logic [3:0] {
		PH_HUNT1,
		PH_HUNT2,
		PH_CLASS,
		PH_ID,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_HEADER,
		PH_BLOCK,
		PH_SKIP
	} phase_t;

	phase_t      phase_q;
	logic [4:0]  cnt_q;
	logic [15:0] rem_q;
	logic [7:0]  len_lo_q;

	logic        take;
	logic [15:0] len_full;
	logic [15:0] rem_hdr;
	logic [15:0] rem_blk;
	logic        hdr_last;
	logic        blk_last;

	assign take     = byte_valid && byte_ready;
	assign len_full = {byte_data, len_lo_q};
	assign rem_hdr  = (len_full >= 16'(HEADER_BYTES)) ? len_full - 16'(HEADER_BYTES) : '0;
	assign rem_blk  = rem_q - 16'(BLOCK_BYTES);
	assign hdr_last = rem_q < 16'(BLOCK_BYTES);
	assign blk_last = rem_blk < 16'(BLOCK_BYTES);

	// tag the current byte
	always_comb begin
		tok.data  = byte_data;
		tok.op    = OP_TOW;
		tok.last  = 1'b0;
		tok_valid = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				tok_valid = take;
				if (cnt_q < 5'd4) begin
					tok.op = OP_TOW;
				end else if (cnt_q < 5'd6) begin
					tok.op = OP_WEEK;
				end else if (cnt_q == 5'd6) begin
					tok.op = OP_NSV;
				end else begin
					tok.op   = OP_HDR_END;
					tok.last = hdr_last;
				end
			end
			PH_BLOCK: begin
				tok_valid = take;
				if (cnt_q < 5'd8) begin
					tok.op = OP_PHASE;
				end else if (cnt_q < 5'd16) begin
					tok.op = OP_RANGE;
				end else if (cnt_q < 5'd20) begin
					tok.op = OP_DOPPLER;
				end else if (cnt_q < 5'd23) begin
					tok.op = OP_SMALL;
				end else begin
					tok.op   = OP_BLK_END;
					tok.last = blk_last;
				end
			end
			default: begin
				tok_valid = 1'b0;
			end
		endcase
	end

	// frame walker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT1;
			cnt_q    <= '0;
			rem_q    <= '0;
			len_lo_q <= '0;
		end else if (take) begin
			unique case (phase_q)
				PH_HUNT2: begin
					phase_q <= (byte_data == SYNC_SECOND) ? PH_CLASS : PH_HUNT1;
				end
				PH_CLASS: begin
					phase_q <= PH_ID;
				end
				PH_ID: begin
					phase_q <= PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_lo_q <= byte_data;
					phase_q  <= PH_LEN_HI;
				end
				PH_LEN_HI: begin
					rem_q   <= rem_hdr;
					cnt_q   <= '0;
					phase_q <= PH_HEADER;
				end
				PH_HEADER: begin
					if (cnt_q == 5'(HEADER_BYTES - 1)) begin
						if (hdr_last) begin
							cnt_q   <= rem_q[4:0] + 5'd2;
							phase_q <= PH_SKIP;
						end else begin
							cnt_q   <= '0;
							phase_q <= PH_BLOCK;
						end
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				PH_BLOCK: begin
					if (cnt_q == 5'(BLOCK_BYTES - 1)) begin
						rem_q <= rem_blk;
						if (blk_last) begin
							cnt_q   <= rem_blk[4:0] + 5'd2;
							phase_q <= PH_SKIP;
						end else begin
							cnt_q <= '0;
						end
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				PH_SKIP: begin
					if (cnt_q <= 5'd1) begin
						cnt_q   <= '0;
						phase_q <= PH_HUNT1;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				default: begin
					phase_q <= (byte_data == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
				end
			endcase
		end
	end

endmodule

>>> rtl/ubx_fifo.sv
// ----------------------------------------------------------------------------
// ubx_fifo: token queue
// Small first-in first-out store that lets the classifier and the result
// assembler stall independently.
// ----------------------------------------------------------------------------
module ubx_fifo #(
	parameter int DEPTH = ubx_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ubx_pkg::tok_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output ubx_pkg::tok_t out_data
);
	import ubx_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tok_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign in_ready  = count_q != CW'(DEPTH);
	assign out_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> rtl/ubx_back.sv
// ----------------------------------------------------------------------------
// ubx_back: result assembler
// Shifts tagged bytes into little-endian field registers and loads the
// output register with a header or record result on each closing byte.
// ----------------------------------------------------------------------------
module ubx_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       tok_valid,
	output logic                       tok_ready,
	input  ubx_pkg::tok_t              tok,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [ubx_pkg::OUT_W-1:0]  m_tdata,  // rcv_tow, week, num_sv, carrier_phase,
	                                             // pseudorange, doppler, sv_id, quality,
	                                             // cno, lock_loss
	output logic                       m_tuser,  // kind
	output logic                       m_tlast
);
	import ubx_pkg::*;

	logic [31:0] tow_q;
	logic [15:0] week_q;
	logic [7:0]  nsv_q;
	logic [63:0] phase_q;
	logic [63:0] range_q;
	logic [31:0] dop_q;
	logic [23:0] small_q;

	logic        is_end;
	logic        out_free;
	logic        pop;

	assign is_end    = (tok.op == OP_HDR_END) || (tok.op == OP_BLK_END);
	assign out_free  = !m_tvalid || m_tready;
	assign tok_ready = !is_end || out_free;
	assign pop       = tok_valid && tok_ready;

	// field accumulators, low byte first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tow_q   <= '0;
			week_q  <= '0;
			nsv_q   <= '0;
			phase_q <= '0;
			range_q <= '0;
			dop_q   <= '0;
			small_q <= '0;
		end else if (pop) begin
			unique case (tok.op)
				OP_TOW:     tow_q   <= {tok.data, tow_q[31:8]};
				OP_WEEK:    week_q  <= {tok.data, week_q[15:8]};
				OP_NSV:     nsv_q   <= tok.data;
				OP_PHASE:   phase_q <= {tok.data, phase_q[63:8]};
				OP_RANGE:   range_q <= {tok.data, range_q[63:8]};
				OP_DOPPLER: dop_q   <= {tok.data, dop_q[31:8]};
				OP_SMALL:   small_q <= {tok.data, small_q[23:8]};
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= KIND_HEADER;
			m_tlast  <= 1'b0;
		end else if (pop && is_end) begin
			m_tvalid <= 1'b1;
			m_tlast  <= tok.last;
			if (tok.op == OP_HDR_END) begin
				m_tuser <= KIND_HEADER;
				m_tdata <= {192'd0, nsv_q, week_q, tow_q};
			end else begin
				m_tuser <= KIND_RECORD;
				m_tdata <= {tok.data, small_q[23:16], small_q[15:8], small_q[7:0],
					dop_q, range_q, phase_q, 56'd0};
			end
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

endmodule

>>> rtl/ubx_raw_message_parser.sv
// ----------------------------------------------------------------------------
// ubx_raw_message_parser: raw-measurement frame parser
// Takes receiver bytes on the slave stream and emits one header result and
// one result per satellite block on the master stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one received byte per transaction in s_tdata.
//   m_* carries results: m_tuser is the kind (0 header, 1 satellite record),
//   m_tlast marks the final result of a frame, m_tdata packs all fields,
//   with the fields that do not belong to the kind at zero.
//   Throughput is one byte per cycle while s_tready is high; the classifier
//   walks the frame one byte a cycle and the assembler drains one token a
//   cycle unless a closing token waits for a busy output register. With no
//   backlog in the queue, the token of a closing byte is written into the
//   queue and then moves into the output register that presents the result.
//   When the receiver stalls, the output register holds its result and the
//   assembler keeps absorbing field bytes; the queue fills only on the next
//   closing byte, and s_tready falls once the queue is full.
//   Reset returns the parser to sync hunting and empties queue and output.
// ----------------------------------------------------------------------------
module ubx_raw_message_parser #(
	parameter int QUEUE_DEPTH = ubx_pkg::QUEUE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,   // rx_byte
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [ubx_pkg::OUT_W-1:0] m_tdata,   // rcv_tow, week, num_sv, carrier_phase,
	                                             // pseudorange, doppler, sv_id, quality,
	                                             // cno, lock_loss
	output logic                      m_tuser,   // kind
	output logic                      m_tlast
);
	import ubx_pkg::*;

	logic q_in_valid;
	logic q_in_ready;
	tok_t q_in_data;
	logic q_out_valid;
	logic q_out_ready;
	tok_t q_out_data;

	assign s_tready = q_in_ready;

	// byte classifier
	ubx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (s_tvalid),
		.byte_ready (q_in_ready),
		.byte_data  (s_tdata),
		.tok_valid  (q_in_valid),
		.tok        (q_in_data)
	);

	// token queue
	ubx_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_in_valid),
		.in_ready  (q_in_ready),
		.in_data   (q_in_data),
		.out_valid (q_out_valid),
		.out_ready (q_out_ready),
		.out_data  (q_out_data)
	);

	// result assembler
	ubx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (q_out_valid),
		.tok_ready (q_out_ready),
		.tok       (q_out_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
